// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the handle pool RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define RHP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("handle pool assertion failed");
`define RHP_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("handle pool forbidden condition");
`else
`define RHP_ASSERT(lbl, clk, rst_n, prop)
`define RHP_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/rhp_pkg.sv =====
// Shared types and constants of the refcounted handle pool.
// No dependencies; used by the count table, free FIFO and top level.
`default_nettype none

package rhp_pkg;

    localparam int KIND_W   = 2;
    localparam int HANDLE_W = 4;

    // Request kinds
    localparam logic [KIND_W-1:0] K_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] K_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] K_ADDREF  = 2'd2;
    localparam logic [KIND_W-1:0] K_QUERY   = 2'd3;

    // Commands to the free FIFO and fresh-handle counter
    typedef struct packed {
        logic rd;          // read the head entry
        logic pop;         // drop the head entry
        logic push;        // append a handle at the tail
        logic take_fresh;  // consume the next never-used handle
    } t_fifo_cmd;

    // Status from the free FIFO
    typedef struct packed {
        logic has_free;    // FIFO holds at least one handle
        logic has_fresh;   // a never-used handle remains
    } t_fifo_stat;

    // Commands to the count table
    typedef struct packed {
        logic rd;
        logic wr;
    } t_cnt_cmd;

endpackage

`default_nettype wire

// ===== rtl/rhp_count_table.sv =====
// Reference count memory with one read and one write port, registered read.
// Held bits in flip-flops mark entries with a nonzero count; depends on rhp_pkg.
`default_nettype none

module rhp_count_table #(
    parameter int POOL_SIZE = 16,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  rhp_pkg::t_cnt_cmd     i_cmd,
    input  wire  [IDX_W-1:0]      i_rd_addr,
    input  wire  [IDX_W-1:0]      i_wr_addr,
    input  wire  [CNT_W-1:0]      i_wr_data,
    output logic [CNT_W-1:0]      o_rd_count,
    output logic                  o_rd_held
);

    logic [CNT_W-1:0]     r_mem [POOL_SIZE];
    logic [POOL_SIZE-1:0] r_held;
    logic [CNT_W-1:0]     r_rd_count;
    logic                 r_rd_held;

    // Write the count memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read count and held bit together
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_count <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_held <= 1'b0;
        end else if (i_cmd.rd) begin
            r_rd_held <= r_held[i_rd_addr];
        end
    end

    // Track nonzero counts; reset marks every handle free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.wr) begin
            r_held[i_wr_addr] <= (i_wr_data != '0);
        end
    end

    assign o_rd_count = r_rd_count;
    assign o_rd_held  = r_rd_held;

endmodule

`default_nettype wire

// ===== rtl/rhp_free_fifo.sv =====
// Free-handle FIFO in a synchronous memory plus the never-used handle counter.
// Depends on rhp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rhp_free_fifo #(
    parameter int POOL_SIZE = 16,
    parameter int IDX_W     = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  rhp_pkg::t_fifo_cmd    i_cmd,
    input  wire  [IDX_W-1:0]      i_push_handle,
    output logic [IDX_W-1:0]      o_head_handle,
    output logic [IDX_W-1:0]      o_fresh_handle,
    output rhp_pkg::t_fifo_stat   o_stat
);

    localparam int LVL_W = $clog2(POOL_SIZE + 1);

    logic [IDX_W-1:0] r_mem [POOL_SIZE];
    logic [IDX_W-1:0] r_rd_data;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [LVL_W-1:0] r_level, n_level;
    logic [LVL_W-1:0] r_fresh, n_fresh;
    logic             w_push_ok;
    logic             w_pop_ok;

    assign w_push_ok = i_cmd.push && (r_level < LVL_W'(POOL_SIZE));
    assign w_pop_ok  = i_cmd.pop && (r_level != '0);

    // Write at the tail
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_tail] <= i_push_handle;
        end
    end

    // Read the head entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    // Advance pointers, level and fresh counter
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_level = r_level;
        n_fresh = r_fresh;
        if (w_pop_ok) begin
            n_head = (r_head == IDX_W'(POOL_SIZE - 1)) ? '0 : r_head + 1'b1;
        end
        if (w_push_ok) begin
            n_tail = (r_tail == IDX_W'(POOL_SIZE - 1)) ? '0 : r_tail + 1'b1;
        end
        if (w_pop_ok && !w_push_ok) begin
            n_level = r_level - 1'b1;
        end else if (w_push_ok && !w_pop_ok) begin
            n_level = r_level + 1'b1;
        end
        if (i_cmd.take_fresh && (r_fresh < LVL_W'(POOL_SIZE))) begin
            n_fresh = r_fresh + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
            r_fresh <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_level <= n_level;
            r_fresh <= n_fresh;
        end
    end

    assign o_head_handle    = r_rd_data;
    assign o_fresh_handle   = IDX_W'(r_fresh);
    assign o_stat.has_free  = (r_level != '0);
    assign o_stat.has_fresh = (r_fresh < LVL_W'(POOL_SIZE));

    // Level and fresh counter stay within the pool
    `RHP_ASSERT(a_level_bound, i_clk, i_rst_n, r_level <= LVL_W'(POOL_SIZE))
    // A freed handle is never held, so the FIFO has room for it
    `RHP_NEVER(a_push_full, i_clk, i_rst_n, i_cmd.push && (r_level == LVL_W'(POOL_SIZE)))
    // Queued handles cannot exceed the fresh-consumed handles
    `RHP_ASSERT(a_level_fresh, i_clk, i_rst_n, r_level <= r_fresh)

endmodule

`default_nettype wire

// ===== rtl/refcounted_handle_pool_unit.sv =====
// Refcounted handle pool: accepts one request, answers one result.
// A request is accepted in idle, where the count memory and FIFO head are read;
// lookup then writes the count back and loads the result register. No new request
// is taken during lookup. A waiting result lets the next request in, which then holds
// in lookup until the result is taken.
// Reset clears held bits, FIFO pointers and the fresh counter at once; no sweep.
`default_nettype none
`include "assert_macros.svh"

module refcounted_handle_pool_unit #(
    parameter int POOL_SIZE      = 16,
    parameter int MAX_REFERENCES = 255
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire  [rhp_pkg::KIND_W-1:0]    i_kind,
    input  wire  [rhp_pkg::HANDLE_W-1:0]  i_handle,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [rhp_pkg::HANDLE_W-1:0]  o_result_handle,
    output logic                          o_ok,
    output logic                          o_shared,
    output logic                          o_freed,
    output logic                          o_saturated
);

    localparam int IDX_W = $clog2(POOL_SIZE);
    localparam int CNT_W = $clog2(MAX_REFERENCES + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    logic                          r_state, n_state;
    logic [rhp_pkg::KIND_W-1:0]    r_kind;
    logic [rhp_pkg::HANDLE_W-1:0]  r_handle;
    logic                          r_out_valid;
    logic [rhp_pkg::HANDLE_W-1:0]  r_res_handle;
    logic                          r_ok, r_shared, r_freed, r_sat;
    logic [rhp_pkg::HANDLE_W-1:0]  n_res_handle;
    logic                          n_ok, n_shared, n_freed, n_sat;

    logic                          w_in_acc;
    logic                          w_compute;
    logic                          w_in_range_in;
    logic                          w_in_range;
    logic                          w_held;
    logic                          w_is_alloc;
    logic                          w_pool_dry;
    logic [IDX_W-1:0]              w_rd_addr;
    logic [IDX_W-1:0]              w_idx;
    logic [IDX_W-1:0]              w_grant;
    logic [CNT_W-1:0]              w_cnt;
    logic [CNT_W-1:0]              w_new_cnt;
    logic [IDX_W-1:0]              w_wr_addr;
    logic [CNT_W-1:0]              w_wr_data;

    rhp_pkg::t_cnt_cmd             w_cnt_cmd;
    rhp_pkg::t_fifo_cmd            w_fifo_cmd;
    rhp_pkg::t_fifo_stat           w_fifo_stat;
    logic [IDX_W-1:0]              w_head_handle;
    logic [IDX_W-1:0]              w_fresh_handle;

    // Handshake
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_compute  = (r_state == ST_LOOKUP) && (!r_out_valid || i_out_ready);

    // Read address: out-of-range handles read entry zero and are masked later
    assign w_in_range_in = ({{(32 - rhp_pkg::HANDLE_W){1'b0}}, i_handle}
                            < 32'(POOL_SIZE));
    assign w_rd_addr     = w_in_range_in ? IDX_W'(i_handle) : '0;
    assign w_in_range    = ({{(32 - rhp_pkg::HANDLE_W){1'b0}}, r_handle}
                            < 32'(POOL_SIZE));
    assign w_idx         = IDX_W'(r_handle);

    // Allocation request and pool with nothing left to grant
    assign w_is_alloc = (r_kind == rhp_pkg::K_ALLOC);
    assign w_pool_dry = !w_fifo_stat.has_free && !w_fifo_stat.has_fresh;

    rhp_count_table #(
        .POOL_SIZE (POOL_SIZE),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_count_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cnt_cmd),
        .i_rd_addr  (w_rd_addr),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data),
        .o_rd_count (w_cnt),
        .o_rd_held  (w_held)
    );

    rhp_free_fifo #(
        .POOL_SIZE (POOL_SIZE),
        .IDX_W     (IDX_W)
    ) u_free_fifo (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_fifo_cmd),
        .i_push_handle  (w_idx),
        .o_head_handle  (w_head_handle),
        .o_fresh_handle (w_fresh_handle),
        .o_stat         (w_fifo_stat)
    );

    // Modify the looked-up count and decide the result
    always_comb begin
        w_cnt_cmd.rd          = w_in_acc;
        w_cnt_cmd.wr          = 1'b0;
        w_fifo_cmd.rd         = w_in_acc;
        w_fifo_cmd.pop        = 1'b0;
        w_fifo_cmd.push       = 1'b0;
        w_fifo_cmd.take_fresh = 1'b0;
        w_grant               = w_fifo_stat.has_free ? w_head_handle : w_fresh_handle;
        w_wr_addr             = w_idx;
        w_wr_data             = w_cnt;
        w_new_cnt             = w_cnt;
        n_res_handle          = r_handle;
        n_ok                  = 1'b0;
        n_shared              = 1'b0;
        n_freed               = 1'b0;
        n_sat                 = 1'b0;
        if (w_is_alloc) begin
            n_res_handle = '0;
            if (!w_pool_dry) begin
                n_ok                  = 1'b1;
                n_res_handle          = rhp_pkg::HANDLE_W'(w_grant);
                w_cnt_cmd.wr          = w_compute;
                w_wr_addr             = w_grant;
                w_wr_data             = CNT_W'(1);
                w_fifo_cmd.pop        = w_compute && w_fifo_stat.has_free;
                w_fifo_cmd.take_fresh = w_compute && !w_fifo_stat.has_free;
            end
        end else if (w_held && w_in_range) begin
            n_ok = 1'b1;
            case (r_kind)
                rhp_pkg::K_RELEASE: begin
                    w_cnt_cmd.wr = w_compute;
                    if (w_cnt == CNT_W'(1)) begin
                        w_new_cnt       = '0;
                        w_fifo_cmd.push = w_compute;
                        n_freed         = 1'b1;
                    end else begin
                        w_new_cnt = w_cnt - 1'b1;
                    end
                    w_wr_data = w_new_cnt;
                end
                rhp_pkg::K_ADDREF: begin
                    if (w_cnt >= CNT_W'(MAX_REFERENCES)) begin
                        n_sat = 1'b1;
                    end else begin
                        w_new_cnt    = w_cnt + 1'b1;
                        w_wr_data    = w_new_cnt;
                        w_cnt_cmd.wr = w_compute;
                    end
                end
                default: begin
                    w_new_cnt = w_cnt;
                end
            endcase
            n_shared = (w_new_cnt > CNT_W'(1));
        end
    end

    // Sequence: wait for a request, then finish it when the output slot is free
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_in_acc) n_state = ST_LOOKUP;
            ST_LOOKUP: if (w_compute) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_compute) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the request under work
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind   <= i_kind;
            r_handle <= i_handle;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (w_compute) begin
            r_res_handle <= n_res_handle;
            r_ok         <= n_ok;
            r_shared     <= n_shared;
            r_freed      <= n_freed;
            r_sat        <= n_sat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_handle = r_res_handle;
    assign o_ok            = r_ok;
    assign o_shared        = r_shared;
    assign o_freed         = r_freed;
    assign o_saturated     = r_sat;

    // A new result appears only out of the lookup step
    `RHP_ASSERT(a_out_from_lookup, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state == ST_LOOKUP))
    // Freed and saturated results always report a held handle
    `RHP_ASSERT(a_freed_ok, i_clk, i_rst_n, (o_out_valid && o_freed) |-> (o_ok && !o_shared))
    `RHP_ASSERT(a_sat_ok, i_clk, i_rst_n, (o_out_valid && o_saturated) |-> (o_ok && o_shared))
    // An exhausted pool never grants
    `RHP_ASSERT(a_no_grant, i_clk, i_rst_n, (w_compute && w_is_alloc && w_pool_dry) |=> !o_ok)

endmodule

`default_nettype wire
